// ===== rtl/cmfs_pkg.sv =====
`default_nettype none

package cmfs_pkg;

  localparam int IN_BITS      = 16;
  localparam int UV_FRAC_BITS = 16;

  localparam int UV_W       = UV_FRAC_BITS + 1;
  localparam int NUM_W      = IN_BITS + 1;
  localparam int DIV_W      = IN_BITS + UV_FRAC_BITS + 1;
  localparam int N_CELLS    = UV_W;
  localparam int IN_DATA_W  = ((3 * IN_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((3 + 2 * UV_W + 7) / 8) * 8;

  localparam logic [UV_W-1:0] UV_ONE  = {1'b1, {UV_FRAC_BITS{1'b0}}};
  localparam logic [UV_W-1:0] UV_HALF = {2'b01, {(UV_FRAC_BITS - 1){1'b0}}};

  typedef enum logic [2:0] {
    FACE_PX,
    FACE_NX,
    FACE_PY,
    FACE_NY,
    FACE_PZ,
    FACE_NZ
  } face_t;

  typedef struct packed {
    face_t face;
    logic  flip;
    logic  degen;
  } side_t;

  typedef struct packed {
    logic [DIV_W-1:0] ds;
    logic [DIV_W-1:0] rem_u;
    logic [DIV_W-1:0] rem_v;
    logic [UV_W-1:0]  quo_u;
    logic [UV_W-1:0]  quo_v;
    side_t            side;
  } div_t;

  typedef struct packed {
    face_t           face;
    logic [UV_W-1:0] tex_u;
    logic [UV_W-1:0] tex_v;
    logic            degen;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/cmfs_front.sv =====
`default_nettype none

module cmfs_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire logic                           in_valid,
  input  wire logic [cmfs_pkg::IN_BITS-1:0]   dir_x,
  input  wire logic [cmfs_pkg::IN_BITS-1:0]   dir_y,
  input  wire logic [cmfs_pkg::IN_BITS-1:0]   dir_z,
  output logic                                valid_r,
  output cmfs_pkg::div_t                      d_r
);

  logic [cmfs_pkg::IN_BITS-1:0]   ax, ay, az, big, mu, mv;
  logic [cmfs_pkg::IN_BITS+1:0]   sum_u, sum_v;
  logic [cmfs_pkg::NUM_W-1:0]     num_u, num_v;
  cmfs_pkg::face_t                face;
  cmfs_pkg::div_t                 d_nxt;

  always_comb begin
    ax = dir_x[cmfs_pkg::IN_BITS-1] ? (~dir_x + 1'b1) : dir_x;
    ay = dir_y[cmfs_pkg::IN_BITS-1] ? (~dir_y + 1'b1) : dir_y;
    az = dir_z[cmfs_pkg::IN_BITS-1] ? (~dir_z + 1'b1) : dir_z;

    if (ax >= ay && ax >= az) begin
      face = dir_x[cmfs_pkg::IN_BITS-1] ? cmfs_pkg::FACE_NX : cmfs_pkg::FACE_PX;
      big  = ax;
      mu   = dir_z;
      mv   = dir_y;
    end else if (ay >= az) begin
      face = dir_y[cmfs_pkg::IN_BITS-1] ? cmfs_pkg::FACE_NY : cmfs_pkg::FACE_PY;
      big  = ay;
      mu   = dir_x;
      mv   = dir_z;
    end else begin
      face = dir_z[cmfs_pkg::IN_BITS-1] ? cmfs_pkg::FACE_NZ : cmfs_pkg::FACE_PZ;
      big  = az;
      mu   = dir_x;
      mv   = dir_y;
    end

    // The minor component plus the major magnitude is never negative.
    sum_u = {{2{mu[cmfs_pkg::IN_BITS-1]}}, mu} + {2'b00, big};
    sum_v = {{2{mv[cmfs_pkg::IN_BITS-1]}}, mv} + {2'b00, big};
    num_u = sum_u[cmfs_pkg::NUM_W-1:0];
    num_v = sum_v[cmfs_pkg::NUM_W-1:0];

    d_nxt.ds    = {big, {(cmfs_pkg::UV_FRAC_BITS + 1){1'b0}}};
    d_nxt.rem_u = {num_u, {cmfs_pkg::UV_FRAC_BITS{1'b0}}}
                + {{(cmfs_pkg::UV_FRAC_BITS + 1){1'b0}}, big};
    d_nxt.rem_v = {num_v, {cmfs_pkg::UV_FRAC_BITS{1'b0}}}
                + {{(cmfs_pkg::UV_FRAC_BITS + 1){1'b0}}, big};
    d_nxt.quo_u = '0;
    d_nxt.quo_v = '0;
    d_nxt.side.face  = face;
    d_nxt.side.flip  = (face == cmfs_pkg::FACE_PY) || (face == cmfs_pkg::FACE_NY) ||
                       (face == cmfs_pkg::FACE_PZ);
    d_nxt.side.degen = (big == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cmfs_div_cell.sv =====
`default_nettype none

module cmfs_div_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            valid_in,
  input  wire cmfs_pkg::div_t  d_in,
  output logic                 valid_r,
  output cmfs_pkg::div_t       d_r
);

  logic           ge_u, ge_v;
  cmfs_pkg::div_t d_nxt;

  always_comb begin
    ge_u = (d_in.rem_u >= d_in.ds);
    ge_v = (d_in.rem_v >= d_in.ds);
    d_nxt       = d_in;
    d_nxt.ds    = d_in.ds >> 1;
    d_nxt.rem_u = ge_u ? (d_in.rem_u - d_in.ds) : d_in.rem_u;
    d_nxt.rem_v = ge_v ? (d_in.rem_v - d_in.ds) : d_in.rem_v;
    d_nxt.quo_u = {d_in.quo_u[cmfs_pkg::UV_W-2:0], ge_u};
    d_nxt.quo_v = {d_in.quo_v[cmfs_pkg::UV_W-2:0], ge_v};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cmfs_out.sv =====
`default_nettype none

module cmfs_out (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              push_valid,
  input  wire cmfs_pkg::div_t                    push_d,
  output logic                                   ready,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [cmfs_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic                                   out_tuser
);

  logic           out_valid_r, skid_valid_r;
  cmfs_pkg::res_t out_r, skid_r, res;
  logic           push, take;

  always_comb begin
    res.face  = push_d.side.face;
    res.degen = push_d.side.degen;
    if (push_d.side.degen) begin
      res.tex_u = cmfs_pkg::UV_HALF;
      res.tex_v = cmfs_pkg::UV_HALF;
    end else if (push_d.side.flip) begin
      res.tex_u = cmfs_pkg::UV_ONE - push_d.quo_u;
      res.tex_v = cmfs_pkg::UV_ONE - push_d.quo_v;
    end else begin
      res.tex_u = push_d.quo_u;
      res.tex_v = push_d.quo_v;
    end
  end

  assign ready = !skid_valid_r;
  assign push  = push_valid && ready;
  assign take  = out_tready || !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (push) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = cmfs_pkg::OUT_DATA_W'({out_r.tex_v, out_r.tex_u, out_r.face});
  assign out_tuser  = out_r.degen;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a request while the output register is empty");

  a_tex_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.tex_u <= cmfs_pkg::UV_ONE) && (out_r.tex_v <= cmfs_pkg::UV_ONE))
    else $error("texture coordinate above 1.0");

  a_degen_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.degen) |->
      (out_r.face == cmfs_pkg::FACE_PX) && (out_r.tex_u == cmfs_pkg::UV_HALF) &&
      (out_r.tex_v == cmfs_pkg::UV_HALF))
    else $error("zero vector result is not the +x face at the center");

endmodule

`default_nettype wire

// ===== rtl/cube_map_face_select_uv.sv =====
`default_nettype none

// Channel  Direction  Payload
// in_      slave      tdata: dir_x, dir_y, dir_z (signed Q1.15, lowest bits first)
// out_     master     tdata: face, tex_u, tex_v; tuser: degenerate
//
// One request is taken per cycle while the skid register is empty. Its result passes
// through one select stage, one divider cell per coordinate bit, and the output
// register, in that order. The divider cells advance together
// while the skid register is empty. A stalled output is held while one more result
// lands in the skid register. Reset clears only the valid bits; there is no clearing pass.

module cube_map_face_select_uv (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [cmfs_pkg::IN_DATA_W-1:0]    in_tdata,   // dir_x, dir_y, dir_z
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [cmfs_pkg::OUT_DATA_W-1:0]        out_tdata,  // face, tex_u, tex_v
  output logic                                   out_tuser   // degenerate
);

  logic           en;
  logic           stage_v [0:cmfs_pkg::N_CELLS];
  cmfs_pkg::div_t stage_d [0:cmfs_pkg::N_CELLS];

  assign in_tready = en;

  cmfs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .dir_x    (in_tdata[cmfs_pkg::IN_BITS-1:0]),
    .dir_y    (in_tdata[2*cmfs_pkg::IN_BITS-1:cmfs_pkg::IN_BITS]),
    .dir_z    (in_tdata[3*cmfs_pkg::IN_BITS-1:2*cmfs_pkg::IN_BITS]),
    .valid_r  (stage_v[0]),
    .d_r      (stage_d[0])
  );

  for (genvar i = 0; i < cmfs_pkg::N_CELLS; i++) begin : g_cell
    cmfs_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .valid_in (stage_v[i]),
      .d_in     (stage_d[i]),
      .valid_r  (stage_v[i+1]),
      .d_r      (stage_d[i+1])
    );
  end

  cmfs_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (stage_v[cmfs_pkg::N_CELLS]),
    .push_d     (stage_d[cmfs_pkg::N_CELLS]),
    .ready      (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// ===== bench/cube_map_face_select_uv_tb.sv =====
`timescale 1ns / 1ps

module cube_map_face_select_uv_tb;

  localparam int NUM_ITEMS    = 1450;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 400;

  typedef struct {
    logic [cmfs_pkg::IN_BITS-1:0] x;
    logic [cmfs_pkg::IN_BITS-1:0] y;
    logic [cmfs_pkg::IN_BITS-1:0] z;
    bit                           known;
    cmfs_pkg::res_t               want;
  } dir_case_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [cmfs_pkg::IN_DATA_W-1:0]  in_tdata;   // dir_x, dir_y, dir_z
  logic                            out_tvalid;
  logic                            out_tready;
  logic [cmfs_pkg::OUT_DATA_W-1:0] out_tdata;  // face, tex_u, tex_v
  logic                            out_tuser;  // degenerate

  dir_case_t      directed_dirs[$];
  dir_case_t      offered_dirs[$];
  cmfs_pkg::res_t expected_texels[$];
  int             errors;
  int             results_checked;
  int             idle_cycles;

  cube_map_face_select_uv dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  function automatic logic [cmfs_pkg::UV_W-1:0] coord_of(longint m, longint big);
    longint num;
    longint q;
    num = (m + big) * (longint'(1) << cmfs_pkg::UV_FRAC_BITS) + big;
    q = num / (2 * big);
    return q[cmfs_pkg::UV_W-1:0];
  endfunction

  function automatic logic [cmfs_pkg::IN_BITS-1:0] comp_of(int v);
    return v[cmfs_pkg::IN_BITS-1:0];
  endfunction

  function automatic cmfs_pkg::res_t select_face_uv(logic [cmfs_pkg::IN_DATA_W-1:0] d);
    logic signed [cmfs_pkg::IN_BITS-1:0] x, y, z;
    longint lx, ly, lz, ax, ay, az, big, mu, mv;
    cmfs_pkg::res_t r;
    x = d[cmfs_pkg::IN_BITS-1:0];
    y = d[2*cmfs_pkg::IN_BITS-1:cmfs_pkg::IN_BITS];
    z = d[3*cmfs_pkg::IN_BITS-1:2*cmfs_pkg::IN_BITS];
    lx = x;
    ly = y;
    lz = z;
    ax = (lx < 0) ? -lx : lx;
    ay = (ly < 0) ? -ly : ly;
    az = (lz < 0) ? -lz : lz;
    if (ax >= ay && ax >= az) begin
      r.face = (lx >= 0) ? cmfs_pkg::FACE_PX : cmfs_pkg::FACE_NX;
      big = ax; mu = lz; mv = ly;
    end else if (ay >= az) begin
      r.face = (ly >= 0) ? cmfs_pkg::FACE_PY : cmfs_pkg::FACE_NY;
      big = ay; mu = lx; mv = lz;
    end else begin
      r.face = (lz >= 0) ? cmfs_pkg::FACE_PZ : cmfs_pkg::FACE_NZ;
      big = az; mu = lx; mv = ly;
    end
    if (big == 0) begin
      r.tex_u = cmfs_pkg::UV_HALF;
      r.tex_v = cmfs_pkg::UV_HALF;
      r.degen = 1'b1;
    end else begin
      r.tex_u = coord_of(mu, big);
      r.tex_v = coord_of(mv, big);
      r.degen = 1'b0;
      if (r.face == cmfs_pkg::FACE_PY || r.face == cmfs_pkg::FACE_NY ||
          r.face == cmfs_pkg::FACE_PZ) begin
        r.tex_u = cmfs_pkg::UV_ONE - r.tex_u;
        r.tex_v = cmfs_pkg::UV_ONE - r.tex_v;
      end
    end
    return r;
  endfunction

  function automatic dir_case_t dcase(int x, int y, int z, bit known, cmfs_pkg::face_t f,
                                      logic [cmfs_pkg::UV_W-1:0] u,
                                      logic [cmfs_pkg::UV_W-1:0] v,
                                      logic dg);
    dir_case_t c;
    c.x = x[cmfs_pkg::IN_BITS-1:0];
    c.y = y[cmfs_pkg::IN_BITS-1:0];
    c.z = z[cmfs_pkg::IN_BITS-1:0];
    c.known = known;
    c.want.face = f;
    c.want.tex_u = u;
    c.want.tex_v = v;
    c.want.degen = dg;
    return c;
  endfunction

  function automatic dir_case_t random_dir();
    logic signed [cmfs_pkg::IN_BITS-1:0] c [3];
    logic signed [cmfs_pkg::IN_BITS-1:0] b;
    dir_case_t r;
    int k;
    for (int i = 0; i < 3; i++) c[i] = comp_of($urandom);
    k = $urandom_range(0, 2);
    b = comp_of($urandom);
    case ($urandom_range(0, 9))
      4: begin
        for (int i = 0; i < 3; i++) c[i] = comp_of($urandom_range(0, 16) - 8);
      end
      5: begin
        for (int i = 0; i < 3; i++) c[i] = $urandom_range(0, 1) ? b : -b;
        if ($urandom_range(0, 1)) c[k] = comp_of($urandom);
      end
      6: begin
        for (int i = 0; i < 3; i++) begin
          case ($urandom_range(0, 5))
            0: c[i] = comp_of(-32768);
            1: c[i] = comp_of(-32767);
            2: c[i] = comp_of(0);
            3: c[i] = comp_of(1);
            4: c[i] = comp_of(-1);
            default: c[i] = comp_of(32767);
          endcase
        end
      end
      7: begin
        for (int i = 0; i < 3; i++) begin
          case ($urandom_range(0, 3))
            0: c[i] = b;
            1: c[i] = -b;
            2: c[i] = comp_of(b - 1);
            default: c[i] = comp_of(1 - b);
          endcase
        end
        c[k] = $urandom_range(0, 1) ? b : -b;
      end
      8: begin
        c[k] = '0;
        if ($urandom_range(0, 1)) c[(k + 1) % 3] = '0;
      end
      9: begin
        if ($urandom_range(0, 3) == 0) begin
          for (int i = 0; i < 3; i++) c[i] = '0;
        end
      end
      default: ;
    endcase
    r.x = c[0];
    r.y = c[1];
    r.z = c[2];
    r.known = 1'b0;
    r.want = '0;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t mismatch: %s", $time, msg);
    errors++;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    directed_dirs.push_back(dcase(0, 0, 0, 1'b1, cmfs_pkg::FACE_PX,
                                  cmfs_pkg::UV_HALF, cmfs_pkg::UV_HALF, 1'b1));
    directed_dirs.push_back(dcase(32767, 0, 0, 1'b1, cmfs_pkg::FACE_PX,
                                  cmfs_pkg::UV_HALF, cmfs_pkg::UV_HALF, 1'b0));
    directed_dirs.push_back(dcase(-32768, 0, 0, 1'b1, cmfs_pkg::FACE_NX,
                                  cmfs_pkg::UV_HALF, cmfs_pkg::UV_HALF, 1'b0));
    directed_dirs.push_back(dcase(0, 32767, 0, 1'b1, cmfs_pkg::FACE_PY,
                                  cmfs_pkg::UV_HALF, cmfs_pkg::UV_HALF, 1'b0));
    directed_dirs.push_back(dcase(0, -32768, 0, 1'b1, cmfs_pkg::FACE_NY,
                                  cmfs_pkg::UV_HALF, cmfs_pkg::UV_HALF, 1'b0));
    directed_dirs.push_back(dcase(0, 0, 32767, 1'b1, cmfs_pkg::FACE_PZ,
                                  cmfs_pkg::UV_HALF, cmfs_pkg::UV_HALF, 1'b0));
    directed_dirs.push_back(dcase(0, 0, -32768, 1'b1, cmfs_pkg::FACE_NZ,
                                  cmfs_pkg::UV_HALF, cmfs_pkg::UV_HALF, 1'b0));
    directed_dirs.push_back(dcase(-32768, -32768, -32768, 1'b1, cmfs_pkg::FACE_NX,
                                  '0, '0, 1'b0));
    directed_dirs.push_back(dcase(32767, 32767, 32767, 1'b1, cmfs_pkg::FACE_PX,
                                  cmfs_pkg::UV_ONE, cmfs_pkg::UV_ONE, 1'b0));
    directed_dirs.push_back(dcase(32767, -32767, 32767, 1'b1, cmfs_pkg::FACE_PX,
                                  cmfs_pkg::UV_ONE, '0, 1'b0));
    directed_dirs.push_back(dcase(-32767, 32767, 0, 1'b1, cmfs_pkg::FACE_NX,
                                  cmfs_pkg::UV_HALF, cmfs_pkg::UV_ONE, 1'b0));
    directed_dirs.push_back(dcase(0, 32767, -32767, 1'b1, cmfs_pkg::FACE_PY,
                                  cmfs_pkg::UV_HALF, cmfs_pkg::UV_ONE, 1'b0));
    directed_dirs.push_back(dcase(100, -32768, 32767, 1'b0, cmfs_pkg::FACE_PX,
                                  '0, '0, 1'b0));
    directed_dirs.push_back(dcase(1, 0, 0, 1'b1, cmfs_pkg::FACE_PX,
                                  cmfs_pkg::UV_HALF, cmfs_pkg::UV_HALF, 1'b0));
    directed_dirs.push_back(dcase(-1, 1, 1, 1'b1, cmfs_pkg::FACE_NX,
                                  cmfs_pkg::UV_ONE, cmfs_pkg::UV_ONE, 1'b0));
    directed_dirs.push_back(dcase(0, 0, 1, 1'b1, cmfs_pkg::FACE_PZ,
                                  cmfs_pkg::UV_HALF, cmfs_pkg::UV_HALF, 1'b0));
    directed_dirs.push_back(dcase(0, 0, -1, 1'b1, cmfs_pkg::FACE_NZ,
                                  cmfs_pkg::UV_HALF, cmfs_pkg::UV_HALF, 1'b0));
    directed_dirs.push_back(dcase(1, -1, -32768, 1'b0, cmfs_pkg::FACE_PX,
                                  '0, '0, 1'b0));
    directed_dirs.push_back(dcase(32767, -32768, 0, 1'b0, cmfs_pkg::FACE_PX,
                                  '0, '0, 1'b0));
    directed_dirs.push_back(dcase(12345, -23456, 30000, 1'b0, cmfs_pkg::FACE_PX,
                                  '0, '0, 1'b0));
    directed_dirs.push_back(dcase(-20000, 20000, -20001, 1'b0, cmfs_pkg::FACE_PX,
                                  '0, '0, 1'b0));
    directed_dirs.push_back(dcase(32767, 32766, -32767, 1'b0, cmfs_pkg::FACE_PX,
                                  '0, '0, 1'b0));
    directed_dirs.push_back(dcase(-32768, 32767, 32767, 1'b0, cmfs_pkg::FACE_PX,
                                  '0, '0, 1'b0));
    directed_dirs.push_back(dcase(0, -1, 0, 1'b1, cmfs_pkg::FACE_NY,
                                  cmfs_pkg::UV_HALF, cmfs_pkg::UV_HALF, 1'b0));
    directed_dirs.push_back(dcase(1, 1, 0, 1'b1, cmfs_pkg::FACE_PX,
                                  cmfs_pkg::UV_HALF, cmfs_pkg::UV_ONE, 1'b0));
  end

  initial begin
    dir_case_t item;
    int burst_left;
    int gap;
    int num_directed;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    num_directed = directed_dirs.size();
    burst_left = 0;
    for (int i = 0; i < NUM_ITEMS; i++) begin
      if (i == num_directed || i == NUM_ITEMS / 2) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_texels.size() != 0 || offered_dirs.size() != 0) @(posedge clk);
      end
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
      end
      burst_left--;
      item = (i < num_directed) ? directed_dirs[i] : random_dir();
      offered_dirs.push_back(item);
      in_tdata <= {item.z, item.y, item.x};
      in_tvalid <= 1'b1;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_texels.size() != 0 || offered_dirs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && expected_texels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    int mode;
    int len;
    bit held;
    held = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!held && results_checked >= HOLD_AFTER) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      len = $urandom_range(4, 60);
      for (int j = 0; j < len; j++) begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 1) != 0);
          2: out_tready <= ($urandom_range(0, 3) != 0);
          default: out_tready <= (j % 3 == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : scoreboard
    dir_case_t req;
    cmfs_pkg::res_t want;
    logic [2:0] got_face;
    logic [cmfs_pkg::UV_W-1:0] got_u, got_v;
    bit moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_tvalid && in_tready) begin
        moved = 1'b1;
        if (offered_dirs.size() != 0) begin
          req = offered_dirs.pop_front();
        end else begin
          req.known = 1'b0;
        end
        want = req.known ? req.want : select_face_uv(in_tdata);
        expected_texels.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        got_face = out_tdata[2:0];
        got_u = out_tdata[3 +: cmfs_pkg::UV_W];
        got_v = out_tdata[3 + cmfs_pkg::UV_W +: cmfs_pkg::UV_W];
        if (expected_texels.size() == 0) begin
          report_mismatch("result with no request pending");
        end else begin
          want = expected_texels.pop_front();
          if (got_face !== want.face)
            report_mismatch($sformatf("result %0d face got %0d expected %0d",
                                      results_checked, got_face, want.face));
          if (got_u !== want.tex_u)
            report_mismatch($sformatf("result %0d tex_u got %0d expected %0d",
                                      results_checked, got_u, want.tex_u));
          if (got_v !== want.tex_v)
            report_mismatch($sformatf("result %0d tex_v got %0d expected %0d",
                                      results_checked, got_v, want.tex_v));
          if (out_tuser !== want.degen)
            report_mismatch($sformatf("result %0d degenerate got %0b expected %0b",
                                      results_checked, out_tuser, want.degen));
        end
        results_checked++;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule
